// ===== design/dual_pool_bitmap_slot_allocator_assert.svh =====
// Assertion macros shared by the allocator RTL.
`ifndef DUAL_POOL_BITMAP_SLOT_ALLOCATOR_ASSERT_SVH
`define DUAL_POOL_BITMAP_SLOT_ALLOCATOR_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock, off during reset.
`define DPBSA_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("dpbsa: same-cycle check failed");

// Next-cycle implication, sampled on the rising clock, off during reset.
`define DPBSA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("dpbsa: next-cycle check failed");

`endif

// ===== design/dpbsa_pkg.sv =====
package dpbsa_pkg;

	// Default sizing of the two pools
	localparam int QP_COUNT_DEF         = 128;
	localparam int REGION_COUNT_DEF     = 64;
	localparam int REGION_SLOT_LOG2_DEF = 16;
	localparam int QUEUE_SLOT_LOG2_DEF  = 12;
	localparam int RESERVED_QP_DEF      = 2;

	// Field widths
	localparam int ACTION_W   = 2;
	localparam int QP_INDEX_W = 8;
	localparam int SIZE_W     = 32;
	localparam int OFFSET_W   = 35;
	localparam int BASE_W     = 34;
	localparam int STATUS_W   = 2;
	localparam int SLOT_W     = 8;
	localparam int LENGTH_W   = 17;
	localparam int CFG_INDEX_W = 1;

	typedef enum logic [ACTION_W-1:0] {
		ACT_QUEUE_ALLOC  = 2'd0,
		ACT_QUEUE_FREE   = 2'd1,
		ACT_REGION_ALLOC = 2'd2,
		ACT_REGION_FREE  = 2'd3
	} action_t;

	typedef enum logic [STATUS_W-1:0] {
		STATUS_DONE    = 2'd0,
		STATUS_NO_MEM  = 2'd1,
		STATUS_IGNORED = 2'd2
	} status_t;

	typedef enum logic [CFG_INDEX_W-1:0] {
		CFG_QUEUE_TIER_BASE  = 1'b0,
		CFG_REGION_TIER_BASE = 1'b1
	} cfg_reg_t;

	// Decoded request, one flag per pool operation that may go ahead
	typedef struct packed {
		logic q_alloc;
		logic q_free;
		logic r_alloc;
		logic r_free;
	} dec_t;

endpackage

// ===== design/dpbsa_req_if.sv =====
interface dpbsa_req_if;
	import dpbsa_pkg::*;

	logic                  valid;
	logic                  ready;
	logic [ACTION_W-1:0]   action;
	logic [QP_INDEX_W-1:0] qp_index;
	logic [SIZE_W-1:0]     request_size;
	logic [OFFSET_W-1:0]   free_offset;

	modport source (output valid, action, qp_index, request_size, free_offset, input ready);
	modport sink (input valid, action, qp_index, request_size, free_offset, output ready);
endinterface

// ===== design/dpbsa_rsp_if.sv =====
interface dpbsa_rsp_if;
	import dpbsa_pkg::*;

	logic                valid;
	logic                ready;
	logic [STATUS_W-1:0] status;
	logic [SLOT_W-1:0]   slot_index;
	logic [OFFSET_W-1:0] region_offset;
	logic [LENGTH_W-1:0] region_length;

	modport source (output valid, status, slot_index, region_offset, region_length, input ready);
	modport sink (input valid, status, slot_index, region_offset, region_length, output ready);
endinterface

// ===== design/dpbsa_pool.sv =====
module dpbsa_pool #(
	parameter int COUNT    = dpbsa_pkg::QP_COUNT_DEF,
	parameter int RESERVED = 0,
	localparam int IW      = (COUNT > 1) ? $clog2(COUNT) : 1
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          alloc_en,
	input  logic          free_en,
	input  logic [IW-1:0] free_idx,
	output logic          full,
	output logic [IW-1:0] grant_idx
);
	import dpbsa_pkg::*;

	logic [COUNT-1:0] used_q;
	logic [COUNT-1:0] free_vec;
	logic [COUNT-1:0] lowest;

	// Isolate the lowest free slot as a one-hot vector
	assign free_vec = ~used_q;
	assign lowest   = free_vec & (~free_vec + COUNT'(1));
	assign full     = ~|free_vec;

	// Encode the one-hot grant into an index
	always_comb begin
		grant_idx = '0;
		for (int i = 0; i < COUNT; i++) begin
			if (lowest[i]) begin
				grant_idx = grant_idx | IW'(i);
			end
		end
	end

	// Mark the granted slot used, or clear the released one
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < COUNT; i++) begin
				used_q[i] <= (i < RESERVED);
			end
		end else if (alloc_en && !full) begin
			used_q <= used_q | lowest;
		end else if (free_en) begin
			used_q[free_idx] <= 1'b0;
		end
	end

endmodule

// ===== design/dpbsa_decode.sv =====
module dpbsa_decode #(
	parameter int QP_COUNT         = dpbsa_pkg::QP_COUNT_DEF,
	parameter int REGION_COUNT     = dpbsa_pkg::REGION_COUNT_DEF,
	parameter int REGION_SLOT_LOG2 = dpbsa_pkg::REGION_SLOT_LOG2_DEF,
	parameter int RESERVED_QP      = dpbsa_pkg::RESERVED_QP_DEF,
	localparam int QIW = (QP_COUNT > 1) ? $clog2(QP_COUNT) : 1,
	localparam int RIW = (REGION_COUNT > 1) ? $clog2(REGION_COUNT) : 1
) (
	input  dpbsa_pkg::action_t                      action,
	input  logic [dpbsa_pkg::QP_INDEX_W-1:0]        qp_index,
	input  logic [dpbsa_pkg::SIZE_W-1:0]            request_size,
	input  logic [dpbsa_pkg::OFFSET_W-1:0]          free_offset,
	input  logic [dpbsa_pkg::BASE_W-1:0]            region_base,
	output dpbsa_pkg::dec_t                         dec,
	output logic [QIW-1:0]                          q_free_idx,
	output logic [RIW-1:0]                          r_free_idx
);
	import dpbsa_pkg::*;

	localparam logic [SIZE_W:0] SLOT_SIZE = (SIZE_W + 1)'(1) << REGION_SLOT_LOG2;

	logic                  qp_ok;
	logic                  size_ok;
	logic                  below_base;
	logic                  slot_in_range;
	logic [OFFSET_W-1:0]   rel_offset;
	logic [OFFSET_W-1:0]   rel_slot;

	// Queue free: skip reserved slots and indices past the pool
	assign qp_ok = ({1'b0, qp_index} >= (QP_INDEX_W + 1)'(RESERVED_QP))
		&& ({1'b0, qp_index} < (QP_INDEX_W + 1)'(QP_COUNT));
	assign q_free_idx = qp_index[QIW-1:0];

	// Region alloc: size must be non-zero and fit one slot
	assign size_ok = (request_size != '0) && ({1'b0, request_size} <= SLOT_SIZE);

	// Region free: turn the offset back into a slot index
	assign below_base    = free_offset < {1'b0, region_base};
	assign rel_offset    = free_offset - {1'b0, region_base};
	assign rel_slot      = rel_offset >> REGION_SLOT_LOG2;
	assign slot_in_range = rel_slot < OFFSET_W'(REGION_COUNT);
	assign r_free_idx    = rel_slot[RIW-1:0];

	assign dec.q_alloc = (action == ACT_QUEUE_ALLOC);
	assign dec.q_free  = (action == ACT_QUEUE_FREE) && qp_ok;
	assign dec.r_alloc = (action == ACT_REGION_ALLOC) && size_ok;
	assign dec.r_free  = (action == ACT_REGION_FREE) && !below_base && slot_in_range;

endmodule

// ===== design/dual_pool_bitmap_slot_allocator.sv =====
// Channel | Dir | Payload                                            | Handshake
// req     | in  | action, qp_index, request_size, free_offset        | valid/ready
// rsp     | out | status, slot_index, region_offset, region_length   | valid/ready
// cfg     | in  | cfg_index, cfg_data                                | cfg_we only
//
// One transaction per cycle sustained while results are taken; a request passes through the
// input register, then the result register, which presents its result until it is taken.
// The free-slot search is a one-hot lowest-bit isolate and encode over each bitmap.
// Reset sets queue slots below RESERVED_QP used, clears the region map and bases.
// A stalled result holds the input register; req.ready drops only when both registers
// are full and the result is not taken in that cycle.
`include "dual_pool_bitmap_slot_allocator_assert.svh"

module dual_pool_bitmap_slot_allocator #(
	parameter int QP_COUNT         = dpbsa_pkg::QP_COUNT_DEF,
	parameter int REGION_COUNT     = dpbsa_pkg::REGION_COUNT_DEF,
	parameter int REGION_SLOT_LOG2 = dpbsa_pkg::REGION_SLOT_LOG2_DEF,
	parameter int QUEUE_SLOT_LOG2  = dpbsa_pkg::QUEUE_SLOT_LOG2_DEF,
	parameter int RESERVED_QP      = dpbsa_pkg::RESERVED_QP_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [dpbsa_pkg::CFG_INDEX_W-1:0]   cfg_index,
	input  logic [dpbsa_pkg::BASE_W-1:0]        cfg_data,
	dpbsa_req_if.sink                           req,
	dpbsa_rsp_if.source                         rsp
);
	import dpbsa_pkg::*;

	localparam int QIW = (QP_COUNT > 1) ? $clog2(QP_COUNT) : 1;
	localparam int RIW = (REGION_COUNT > 1) ? $clog2(REGION_COUNT) : 1;
	localparam logic [LENGTH_W-1:0] REGION_LEN =
		(REGION_SLOT_LOG2 < LENGTH_W) ? LENGTH_W'(1 << REGION_SLOT_LOG2) : '0;

	logic [BASE_W-1:0]     qbase_q;
	logic [BASE_W-1:0]     rbase_q;

	logic                  valid_s1;
	action_t               action_s1;
	logic [QP_INDEX_W-1:0] qp_index_s1;
	logic [SIZE_W-1:0]     request_size_s1;
	logic [OFFSET_W-1:0]   free_offset_s1;

	logic                  valid_s2;
	status_t               status_s2;
	logic [SLOT_W-1:0]     slot_index_s2;
	logic [OFFSET_W-1:0]   region_offset_s2;
	logic [LENGTH_W-1:0]   region_length_s2;

	logic                  advance;
	dec_t                  dec;
	logic [QIW-1:0]        q_free_idx;
	logic [RIW-1:0]        r_free_idx;
	logic                  q_full;
	logic                  r_full;
	logic [QIW-1:0]        q_grant;
	logic [RIW-1:0]        r_grant;

	status_t               status_nxt;
	logic [SLOT_W-1:0]     slot_nxt;
	logic [OFFSET_W-1:0]   base_nxt;
	logic [OFFSET_W-1:0]   step_nxt;
	logic [LENGTH_W-1:0]   length_nxt;

	// Move the input register on whenever the result register frees up
	assign advance   = valid_s1 && (!valid_s2 || rsp.ready);
	assign req.ready = !valid_s1 || advance;

	// Take configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			qbase_q <= '0;
			rbase_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_QUEUE_TIER_BASE:  qbase_q <= cfg_data;
				CFG_REGION_TIER_BASE: rbase_q <= cfg_data;
			endcase
		end
	end

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.ready) begin
			valid_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			action_s1       <= action_t'(req.action);
			qp_index_s1     <= req.qp_index;
			request_size_s1 <= req.request_size;
			free_offset_s1  <= req.free_offset;
		end
	end

	dpbsa_decode #(
		.QP_COUNT         (QP_COUNT),
		.REGION_COUNT     (REGION_COUNT),
		.REGION_SLOT_LOG2 (REGION_SLOT_LOG2),
		.RESERVED_QP      (RESERVED_QP)
	) u_decode (
		.action       (action_s1),
		.qp_index     (qp_index_s1),
		.request_size (request_size_s1),
		.free_offset  (free_offset_s1),
		.region_base  (rbase_q),
		.dec          (dec),
		.q_free_idx   (q_free_idx),
		.r_free_idx   (r_free_idx)
	);

	dpbsa_pool #(
		.COUNT    (QP_COUNT),
		.RESERVED (RESERVED_QP)
	) u_queue_pool (
		.clk       (clk),
		.arst_n    (arst_n),
		.alloc_en  (advance && dec.q_alloc),
		.free_en   (advance && dec.q_free),
		.free_idx  (q_free_idx),
		.full      (q_full),
		.grant_idx (q_grant)
	);

	dpbsa_pool #(
		.COUNT    (REGION_COUNT),
		.RESERVED (0)
	) u_region_pool (
		.clk       (clk),
		.arst_n    (arst_n),
		.alloc_en  (advance && dec.r_alloc),
		.free_en   (advance && dec.r_free),
		.free_idx  (r_free_idx),
		.full      (r_full),
		.grant_idx (r_grant)
	);

	// Build the result of the action in the input register
	always_comb begin
		status_nxt = STATUS_DONE;
		slot_nxt   = '0;
		base_nxt   = '0;
		step_nxt   = '0;
		length_nxt = '0;
		unique case (action_s1)
			ACT_QUEUE_ALLOC: begin
				if (q_full) begin
					status_nxt = STATUS_NO_MEM;
				end else begin
					slot_nxt = SLOT_W'(q_grant);
					base_nxt = OFFSET_W'(qbase_q);
					step_nxt = OFFSET_W'(q_grant) << QUEUE_SLOT_LOG2;
				end
			end
			ACT_QUEUE_FREE: begin
				status_nxt = dec.q_free ? STATUS_DONE : STATUS_IGNORED;
			end
			ACT_REGION_ALLOC: begin
				if (!dec.r_alloc || r_full) begin
					status_nxt = STATUS_NO_MEM;
				end else begin
					slot_nxt   = SLOT_W'(r_grant);
					base_nxt   = OFFSET_W'(rbase_q);
					step_nxt   = OFFSET_W'(r_grant) << REGION_SLOT_LOG2;
					length_nxt = REGION_LEN;
				end
			end
			ACT_REGION_FREE: begin
				status_nxt = dec.r_free ? STATUS_DONE : STATUS_IGNORED;
			end
		endcase
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (rsp.ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			status_s2        <= status_nxt;
			slot_index_s2    <= slot_nxt;
			region_offset_s2 <= base_nxt + step_nxt;
			region_length_s2 <= length_nxt;
		end
	end

	assign rsp.valid         = valid_s2;
	assign rsp.status        = status_s2;
	assign rsp.slot_index    = slot_index_s2;
	assign rsp.region_offset = region_offset_s2;
	assign rsp.region_length = region_length_s2;

	// A failed or ignored transaction carries no grant
	`DPBSA_ASSERT_IMPL(a_no_grant_on_fail, clk, arst_n,
		valid_s2 && (status_s2 != STATUS_DONE),
		(slot_index_s2 == '0) && (region_offset_s2 == '0) && (region_length_s2 == '0))
	// Both registers full and the result stalled: no new request may be taken
	`DPBSA_ASSERT_IMPL(a_no_overrun, clk, arst_n,
		valid_s1 && valid_s2 && !rsp.ready, !req.ready)
	// A stalled input register keeps its transaction
	`DPBSA_ASSERT_NEXT(a_s1_held, clk, arst_n,
		valid_s1 && valid_s2 && !rsp.ready, valid_s1)

endmodule

// ===== tb/tb_top.sv =====
import dpbsa_pkg::*;

typedef struct {
	action_t               action;
	logic [QP_INDEX_W-1:0] qp_index;
	logic [SIZE_W-1:0]     req_bytes;
	logic [OFFSET_W-1:0]   offset;
} request_t;

typedef struct {
	status_t               status;
	logic [SLOT_W-1:0]     slot;
	logic [OFFSET_W-1:0]   offset;
	logic [LENGTH_W-1:0]   length;
} grant_t;

// Mirror of both slot pools; holds the grants still owed by the allocator
class slot_ledger;
	bit [QP_COUNT_DEF-1:0]     queue_busy;
	bit [REGION_COUNT_DEF-1:0] region_busy;
	bit [BASE_W-1:0]           queue_base;
	bit [BASE_W-1:0]           region_base;
	grant_t                    awaited[$];
	int                        mismatches;

	function new();
		queue_busy  = '0;
		region_busy = '0;
		queue_base  = '0;
		region_base = '0;
		mismatches  = 0;
		for (int i = 0; i < RESERVED_QP_DEF; i++)
			queue_busy[i] = 1'b1;
	endfunction

	function void set_base(cfg_reg_t which, bit [BASE_W-1:0] value);
		if (which == CFG_QUEUE_TIER_BASE)
			queue_base = value;
		else
			region_base = value;
	endfunction

	function int first_free(bit [255:0] map, int count);
		for (int i = 0; i < count; i++)
			if (!map[i])
				return i;
		return -1;
	endfunction

	// Work out the grant for one accepted transaction and update the pools
	function void note_request(request_t r);
		grant_t     g;
		int         slot;
		bit [63:0]  wide;
		g.status = STATUS_DONE;
		g.slot   = '0;
		g.offset = '0;
		g.length = '0;
		case (r.action)
			ACT_QUEUE_ALLOC: begin
				slot = first_free(256'(queue_busy), QP_COUNT_DEF);
				if (slot < 0) begin
					g.status = STATUS_NO_MEM;
				end else begin
					queue_busy[slot] = 1'b1;
					wide     = 64'(queue_base) + (64'(slot) << QUEUE_SLOT_LOG2_DEF);
					g.slot   = SLOT_W'(slot);
					g.offset = wide[OFFSET_W-1:0];
				end
			end
			ACT_QUEUE_FREE: begin
				if (r.qp_index < RESERVED_QP_DEF || r.qp_index >= QP_COUNT_DEF)
					g.status = STATUS_IGNORED;
				else
					queue_busy[r.qp_index] = 1'b0;
			end
			ACT_REGION_ALLOC: begin
				if (r.req_bytes == 0 || 64'(r.req_bytes) > (64'd1 << REGION_SLOT_LOG2_DEF)) begin
					g.status = STATUS_NO_MEM;
				end else begin
					slot = first_free(256'(region_busy), REGION_COUNT_DEF);
					if (slot < 0) begin
						g.status = STATUS_NO_MEM;
					end else begin
						region_busy[slot] = 1'b1;
						wide     = 64'(region_base) + (64'(slot) << REGION_SLOT_LOG2_DEF);
						g.slot   = SLOT_W'(slot);
						g.offset = wide[OFFSET_W-1:0];
						wide     = 64'd1 << REGION_SLOT_LOG2_DEF;
						g.length = wide[LENGTH_W-1:0];
					end
				end
			end
			default: begin
				// Truncate the offset to its slot; drop it below the tier or past the pool
				if (64'(r.offset) < 64'(region_base)) begin
					g.status = STATUS_IGNORED;
				end else begin
					wide = (64'(r.offset) - 64'(region_base)) >> REGION_SLOT_LOG2_DEF;
					if (wide >= REGION_COUNT_DEF)
						g.status = STATUS_IGNORED;
					else
						region_busy[wide[7:0]] = 1'b0;
				end
			end
		endcase
		awaited.push_back(g);
	endfunction

	// Compare one accepted result with the oldest grant owed
	function void check_grant(grant_t got);
		grant_t want;
		if (awaited.size() == 0) begin
			$display("%0t: unexpected result: status %0d slot %0d offset 0x%0h length %0d",
				$time, got.status, got.slot, got.offset, got.length);
			mismatches++;
			return;
		end
		want = awaited.pop_front();
		if (got.status !== want.status) begin
			$display("%0t: status expected %0d got %0d", $time, want.status, got.status);
			mismatches++;
		end
		if (got.slot !== want.slot) begin
			$display("%0t: slot_index expected %0d got %0d", $time, want.slot, got.slot);
			mismatches++;
		end
		if (got.offset !== want.offset) begin
			$display("%0t: region_offset expected 0x%0h got 0x%0h", $time, want.offset,
				got.offset);
			mismatches++;
		end
		if (got.length !== want.length) begin
			$display("%0t: region_length expected %0d got %0d", $time, want.length,
				got.length);
			mismatches++;
		end
	endfunction
endclass

module tb_top;
	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  cfg_we;
	cfg_reg_t              cfg_index;
	logic [BASE_W-1:0]     cfg_data;

	dpbsa_req_if req_ch();
	dpbsa_rsp_if rsp_ch();

	slot_ledger ledger;
	int         send_idle_pct;
	int         take_stall_pct;
	bit         hold_pending;
	int         hold_left;

	dual_pool_bitmap_slot_allocator u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.req       (req_ch),
		.rsp       (rsp_ch)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Build a transaction; fields the action does not use carry random bits
	function automatic request_t shaped(action_t a, logic [63:0] v);
		request_t r;
		r.action    = a;
		r.qp_index  = QP_INDEX_W'($urandom());
		r.req_bytes = $urandom();
		r.offset    = OFFSET_W'({$urandom(), $urandom()});
		case (a)
			ACT_QUEUE_FREE:   r.qp_index  = v[QP_INDEX_W-1:0];
			ACT_REGION_ALLOC: r.req_bytes = v[SIZE_W-1:0];
			ACT_REGION_FREE:  r.offset    = v[OFFSET_W-1:0];
			default:          ;
		endcase
		return r;
	endfunction

	// Mostly well-formed traffic; alloc_bias sets the share of allocations
	function automatic request_t random_request(int alloc_bias);
		int          pick;
		int          roll;
		logic [63:0] v;
		logic [63:0] tier;
		pick = $urandom_range(99);
		roll = $urandom_range(9);
		tier = 64'(ledger.region_base);
		if (pick < alloc_bias / 2)
			return shaped(ACT_QUEUE_ALLOC, '0);
		if (pick < alloc_bias) begin
			case (roll)
				0:       v = 0;
				1:       v = 64'd65537 + $urandom_range(1000);
				2:       v = 64'($urandom());
				3:       v = 64'hFFFF_FFFF;
				default: v = $urandom_range(1, 65536);
			endcase
			return shaped(ACT_REGION_ALLOC, v);
		end
		if (pick < alloc_bias + (100 - alloc_bias) / 2) begin
			if (roll < 7)
				v = $urandom_range(RESERVED_QP_DEF, QP_COUNT_DEF - 1);
			else
				v = $urandom_range(255);
			return shaped(ACT_QUEUE_FREE, v);
		end
		if (roll == 0 || (roll == 1 && tier == 0))
			v = {$urandom(), $urandom()};
		else if (roll == 1)
			v = {$urandom(), $urandom()} % tier;
		else
			v = tier + (64'($urandom_range(0, REGION_COUNT_DEF + 3)) << REGION_SLOT_LOG2_DEF)
				+ $urandom_range(0, 65535);
		return shaped(ACT_REGION_FREE, v);
	endfunction

	// Offer one transaction, idling first at random, and hold it until taken
	task automatic offer(request_t r);
		int gap;
		gap = 0;
		while (gap < 20 && $urandom_range(99) < send_idle_pct)
			gap++;
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_ch.valid        <= 1'b1;
		req_ch.action       <= r.action;
		req_ch.qp_index     <= r.qp_index;
		req_ch.request_size <= r.req_bytes;
		req_ch.free_offset  <= r.offset;
		do
			@(posedge clk);
		while (req_ch.ready !== 1'b1);
		ledger.note_request(r);
	endtask

	task automatic write_reg(cfg_reg_t which, logic [BASE_W-1:0] value);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= which;
		cfg_data  <= value;
		@(posedge clk);
		cfg_we    <= 1'b0;
		ledger.set_base(which, value);
	endtask

	// Wait for every owed grant, then let the pipeline empty
	task automatic settle();
		while (ledger.awaited.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic retune(logic [BASE_W-1:0] queue_tier, logic [BASE_W-1:0] region_tier);
		settle();
		write_reg(CFG_QUEUE_TIER_BASE, queue_tier);
		write_reg(CFG_REGION_TIER_BASE, region_tier);
	endtask

	task automatic run_phase(int count, int alloc_bias);
		repeat (count) offer(random_request(alloc_bias));
		req_ch.valid <= 1'b0;
	endtask

	// Result side: check each transaction, then stall at random or hold off
	initial begin
		grant_t seen;
		rsp_ch.ready <= 1'b0;
		hold_left = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
				seen.status = status_t'(rsp_ch.status);
				seen.slot   = rsp_ch.slot_index;
				seen.offset = rsp_ch.region_offset;
				seen.length = rsp_ch.region_length;
				ledger.check_grant(seen);
			end
			if (hold_pending) begin
				hold_pending = 1'b0;
				hold_left    = 300;
			end
			if (hold_left > 0) begin
				hold_left--;
				rsp_ch.ready <= 1'b0;
			end else begin
				rsp_ch.ready <= ($urandom_range(99) >= take_stall_pct);
			end
		end
	end

	initial begin
		#2000000;
		$display("** dual_pool_bitmap_slot_allocator: FAILED **");
		$finish;
	end

	initial begin
		logic [63:0] tier;
		ledger = new();
		arst_n              <= 1'b0;
		cfg_we              <= 1'b0;
		cfg_index           <= CFG_QUEUE_TIER_BASE;
		cfg_data            <= '0;
		req_ch.valid        <= 1'b0;
		req_ch.action       <= ACT_QUEUE_ALLOC;
		req_ch.qp_index     <= '0;
		req_ch.request_size <= '0;
		req_ch.free_offset  <= '0;
		send_idle_pct  = 0;
		take_stall_pct = 0;
		hold_pending   = 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: reserved and out-of-range frees, bad sizes, slot truncation
		retune(34'h2_0000_1000, 34'h1_0000_0000);
		tier = 64'(ledger.region_base);
		offer(shaped(ACT_QUEUE_ALLOC, '0));
		offer(shaped(ACT_QUEUE_ALLOC, '0));
		offer(shaped(ACT_QUEUE_FREE, 0));
		offer(shaped(ACT_QUEUE_FREE, 1));
		offer(shaped(ACT_QUEUE_FREE, 255));
		offer(shaped(ACT_QUEUE_FREE, QP_COUNT_DEF));
		offer(shaped(ACT_QUEUE_FREE, 2));
		offer(shaped(ACT_QUEUE_FREE, 2));
		offer(shaped(ACT_QUEUE_ALLOC, '0));
		offer(shaped(ACT_REGION_ALLOC, 0));
		offer(shaped(ACT_REGION_ALLOC, 65537));
		offer(shaped(ACT_REGION_ALLOC, 64'hFFFF_FFFF));
		offer(shaped(ACT_REGION_ALLOC, 1));
		offer(shaped(ACT_REGION_ALLOC, 65536));
		offer(shaped(ACT_REGION_FREE, tier - 1));
		offer(shaped(ACT_REGION_FREE, 0));
		offer(shaped(ACT_REGION_FREE, tier + (64'd1 << REGION_SLOT_LOG2_DEF) + 64'hFFFF));
		offer(shaped(ACT_REGION_FREE, tier + (64'd1 << REGION_SLOT_LOG2_DEF)));
		offer(shaped(ACT_REGION_FREE, tier + (64'(REGION_COUNT_DEF) << REGION_SLOT_LOG2_DEF)));
		offer(shaped(ACT_REGION_FREE, 64'h7_FFFF_FFFF));
		offer(shaped(ACT_REGION_ALLOC, 100));
		offer(shaped(ACT_REGION_FREE, tier));
		offer(shaped(ACT_REGION_ALLOC, 4096));
		req_ch.valid <= 1'b0;

		// Top bases, allocation-heavy: drive both pools to full
		retune(34'h3_FFFF_FFFF, 34'h3_FFFF_FFFF);
		run_phase(320, 85);

		// Sender idling, free-heavy: drain the pools
		retune('0, BASE_W'({$urandom(), $urandom()}));
		send_idle_pct = 46;
		run_phase(240, 30);

		// Receiver stalling, with one long hold-off to back up the input
		retune(BASE_W'({$urandom(), $urandom()}), '0);
		send_idle_pct  = 0;
		take_stall_pct = 46;
		hold_pending   = 1'b1;
		run_phase(240, 60);

		// Light idling on both sides
		retune(BASE_W'({$urandom(), $urandom()}), BASE_W'({$urandom(), $urandom()}));
		send_idle_pct  = 12;
		take_stall_pct = 12;
		run_phase(240, 50);

		settle();
		if (ledger.mismatches == 0 && ledger.awaited.size() == 0)
			$display("** dual_pool_bitmap_slot_allocator: PASSED **");
		else
			$display("** dual_pool_bitmap_slot_allocator: FAILED **");
		$finish;
	end
endmodule
